// ===== rtl/tccw_pkg.sv =====
package tccw_pkg;

   // payload widths
   localparam int CHAR_W  = 8;
   localparam int CELL_W  = 13;
   localparam int COUNT_W = 8;

   // register widths
   localparam int COLUMNS_W   = 8;
   localparam int ROWS_W      = 7;
   localparam int START_ROW_W = 6;
   localparam int START_COL_W = 7;

   // configuration port
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] REG_COLUMNS   = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ROWS      = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_START_ROW = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_START_COL = 4'd3;

   localparam logic [COLUMNS_W-1:0] COLUMNS_RESET = 8'd80;
   localparam logic [ROWS_W-1:0]    ROWS_RESET    = 7'd25;

   // character codes
   localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;

   // reciprocal shift for the tab stop division
   localparam int TAB_SHIFT = 16;

endpackage

// ===== rtl/tccw_step.sv =====
module tccw_step
   import tccw_pkg::*;
#(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64,
   parameter int TAB_STOP = 8,
   localparam int NC_W   = $clog2(MAX_COLS + 1),
   localparam int NR_W   = $clog2(MAX_ROWS + 1),
   localparam int COL_W  = $clog2(MAX_COLS),
   localparam int ROW_W  = $clog2(MAX_ROWS),
   localparam int ROW_SW = (ROW_W > START_ROW_W) ? ROW_W : START_ROW_W,
   localparam int COL_SW = (COL_W > START_COL_W) ? COL_W : START_COL_W
) (
   input  logic [ROW_SW-1:0]  cur_row,
   input  logic [COL_SW-1:0]  cur_col,
   input  logic [NC_W-1:0]    nc,
   input  logic [NR_W-1:0]    nr,
   input  logic [CHAR_W-1:0]  ch,
   output logic [ROW_W-1:0]   fill_row,
   output logic [COL_W-1:0]   fill_col,
   output logic [CHAR_W-1:0]  fill_char,
   output logic [NC_W-1:0]    fill_count,
   output logic [ROW_W-1:0]   next_row,
   output logic [COL_W-1:0]   next_col,
   output logic               overflow
);

   localparam int SW     = $clog2(MAX_COLS + TAB_STOP + 1);
   localparam int RECIP  = ((1 << TAB_SHIFT) + TAB_STOP - 1) / TAB_STOP;
   localparam int PROD_W = COL_W + TAB_SHIFT + 1;

   localparam logic [SW-1:0]          TAB_V   = SW'(TAB_STOP);
   localparam logic [TAB_SHIFT:0]     RECIP_V = (TAB_SHIFT + 1)'(RECIP);

   logic [ROW_W-1:0]  row;
   logic [COL_W-1:0]  col;
   logic [PROD_W-1:0] tab_prod;
   logic [COL_W-1:0]  tab_q;
   logic [SW-1:0]     tab_stop;
   logic [SW-1:0]     stop;
   logic [SW-1:0]     nc_w;
   logic [ROW_W:0]    row_inc;
   logic [ROW_W:0]    nr_w;

   // saturate the cursor into the grid before use
   always_comb begin
      if (32'(cur_row) >= 32'(nr)) begin
         row = ROW_W'(nr - NR_W'(1));
      end else begin
         row = ROW_W'(cur_row);
      end
      if (32'(cur_col) >= 32'(nc)) begin
         col = COL_W'(nc - NC_W'(1));
      end else begin
         col = COL_W'(cur_col);
      end
   end

   // next multiple of the tab width above col
   assign tab_prod = PROD_W'(col) * PROD_W'(RECIP_V);
   assign tab_q    = tab_prod[TAB_SHIFT +: COL_W];
   assign tab_stop = (SW'(tab_q) + SW'(1)) * TAB_V;

   assign nc_w = SW'(nc);
   assign nr_w = (ROW_W + 1)'(nr);

   always_comb begin
      fill_row   = row;
      fill_col   = col;
      fill_char  = CH_SPACE;
      fill_count = '0;
      next_row   = row;
      next_col   = col;
      overflow   = 1'b0;
      stop       = SW'(col) + SW'(1);
      row_inc    = (ROW_W + 1)'(row);

      if (ch == CH_BS) begin
         if (row == '0 && col == '0) begin
            fill_char = CH_NONE;
         end else begin
            if (col != '0) begin
               next_col = col - COL_W'(1);
            end else begin
               next_row = row - ROW_W'(1);
               next_col = COL_W'(nc - NC_W'(1));
            end
            fill_row   = next_row;
            fill_col   = next_col;
            fill_count = NC_W'(1);
         end
      end else begin
         if (ch == CH_CR || ch == CH_LF) begin
            stop = nc_w;
         end else if (ch == CH_TAB) begin
            stop = (tab_stop > nc_w) ? nc_w : tab_stop;
         end else begin
            fill_char = ch;
         end
         fill_count = NC_W'(stop - SW'(col));
         if (stop >= nc_w) begin
            next_col = '0;
            row_inc  = (ROW_W + 1)'(row) + (ROW_W + 1)'(1);
         end else begin
            next_col = COL_W'(stop);
         end
         if (row_inc >= nr_w) begin
            next_row = ROW_W'(nr - NR_W'(1));
            overflow = 1'b1;
         end else begin
            next_row = ROW_W'(row_inc);
         end
      end
   end

endmodule

// ===== rtl/tccw_index.sv =====
module tccw_index
   import tccw_pkg::*;
#(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64,
   localparam int NC_W  = $clog2(MAX_COLS + 1),
   localparam int COL_W = $clog2(MAX_COLS),
   localparam int ROW_W = $clog2(MAX_ROWS)
) (
   input  logic [ROW_W-1:0]  row,
   input  logic [COL_W-1:0]  col,
   input  logic [NC_W-1:0]   nc,
   output logic [CELL_W-1:0] cell_idx
);

   localparam int PW    = ROW_W + NC_W + 1;

   logic [PW-1:0] sum;

   // row * columns + column, kept to the cell index width
   assign sum      = PW'(row) * PW'(nc) + PW'(col);
   assign cell_idx = CELL_W'(sum);

endmodule

// ===== rtl/text_console_cursor_writer_core.sv =====
// Text console cursor writer: each character word on req_ gives one fill run
// on rsp_ (start cell, character, cell count) plus the new cursor cell and a
// row overflow flag. One character is taken every clock cycle while req_stall
// is low; a result passes through the first-stage register and then the output
// register. The cursor row/column update is combinational through the step
// logic, and the cell index multiply sits in the second stage in front of the
// output register. Register writes on csr_ are always taken; writing start_row
// or start_col moves the cursor at once. Write registers only while no
// character is in flight.
module text_console_cursor_writer_core
   import tccw_pkg::*;
#(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64,
   parameter int TAB_STOP = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [CHAR_W-1:0]       req_ch,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [CELL_W-1:0]       rsp_fill_start,
   output logic [CHAR_W-1:0]       rsp_fill_char,
   output logic [COUNT_W-1:0]      rsp_fill_count,
   output logic [CELL_W-1:0]       rsp_cursor_pos,
   output logic                    rsp_row_overflow,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   localparam int NC_W   = $clog2(MAX_COLS + 1);
   localparam int NR_W   = $clog2(MAX_ROWS + 1);
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int ROW_SW = (ROW_W > START_ROW_W) ? ROW_W : START_ROW_W;
   localparam int COL_SW = (COL_W > START_COL_W) ? COL_W : START_COL_W;

   logic [COLUMNS_W-1:0] columns_ff, columns_in;
   logic [ROWS_W-1:0]    rows_ff, rows_in;
   logic [ROW_SW-1:0]    cur_row_ff, cur_row_in;
   logic [COL_SW-1:0]    cur_col_ff, cur_col_in;

   logic [NC_W-1:0] nc;
   logic [NR_W-1:0] nr;

   logic              csr_write;
   logic              accept;
   logic              s1_free;
   logic              out_open;

   logic [ROW_W-1:0]  step_fill_row;
   logic [COL_W-1:0]  step_fill_col;
   logic [CHAR_W-1:0] step_fill_char;
   logic [NC_W-1:0]   step_fill_count;
   logic [ROW_W-1:0]  step_next_row;
   logic [COL_W-1:0]  step_next_col;
   logic              step_overflow;

   // first stage: step result
   logic              s1_valid_ff, s1_valid_in;
   logic [ROW_W-1:0]  s1_frow_ff, s1_frow_in;
   logic [COL_W-1:0]  s1_fcol_ff, s1_fcol_in;
   logic [CHAR_W-1:0] s1_char_ff, s1_char_in;
   logic [NC_W-1:0]   s1_count_ff, s1_count_in;
   logic [ROW_W-1:0]  s1_row_ff, s1_row_in;
   logic [COL_W-1:0]  s1_col_ff, s1_col_in;
   logic              s1_ovf_ff, s1_ovf_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0]  rsp_start_ff, rsp_start_in;
   logic [CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [CELL_W-1:0]  rsp_cursor_ff, rsp_cursor_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   logic [CELL_W-1:0]  fill_cell;
   logic [CELL_W-1:0]  cursor_cell;

   // effective grid size, saturated into range
   assign nc = (columns_ff == '0) ? NC_W'(1) :
               (32'(columns_ff) > 32'(MAX_COLS)) ? NC_W'(MAX_COLS) : NC_W'(columns_ff);
   assign nr = (rows_ff == '0) ? NR_W'(1) :
               (32'(rows_ff) > 32'(MAX_ROWS)) ? NR_W'(MAX_ROWS) : NR_W'(rows_ff);

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   // handshake: the output register frees the first stage when it moves on
   assign out_open  = ~rsp_valid_ff | ~rsp_stall;
   assign s1_free   = ~s1_valid_ff | out_open;
   assign req_stall = ~s1_free;
   assign accept    = req_valid & s1_free;

   tccw_step #(
      .MAX_COLS(MAX_COLS),
      .MAX_ROWS(MAX_ROWS),
      .TAB_STOP(TAB_STOP)
   ) u_step (
      .cur_row    (cur_row_ff),
      .cur_col    (cur_col_ff),
      .nc         (nc),
      .nr         (nr),
      .ch         (req_ch),
      .fill_row   (step_fill_row),
      .fill_col   (step_fill_col),
      .fill_char  (step_fill_char),
      .fill_count (step_fill_count),
      .next_row   (step_next_row),
      .next_col   (step_next_col),
      .overflow   (step_overflow)
   );

   tccw_index #(
      .MAX_COLS(MAX_COLS),
      .MAX_ROWS(MAX_ROWS)
   ) u_fill_index (
      .row      (s1_frow_ff),
      .col      (s1_fcol_ff),
      .nc       (nc),
      .cell_idx (fill_cell)
   );

   tccw_index #(
      .MAX_COLS(MAX_COLS),
      .MAX_ROWS(MAX_ROWS)
   ) u_cursor_index (
      .row      (s1_row_ff),
      .col      (s1_col_ff),
      .nc       (nc),
      .cell_idx (cursor_cell)
   );

   // registers and cursor state
   always_comb begin
      columns_in = columns_ff;
      rows_in    = rows_ff;
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      if (csr_write) begin
         case (csr_index)
            REG_COLUMNS:   columns_in = COLUMNS_W'(csr_data);
            REG_ROWS:      rows_in = ROWS_W'(csr_data);
            REG_START_ROW: cur_row_in = ROW_SW'(csr_data[START_ROW_W-1:0]);
            REG_START_COL: cur_col_in = COL_SW'(csr_data[START_COL_W-1:0]);
            default: ;
         endcase
      end else if (accept) begin
         cur_row_in = ROW_SW'(step_next_row);
         cur_col_in = COL_SW'(step_next_col);
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_frow_in  = s1_frow_ff;
      s1_fcol_in  = s1_fcol_ff;
      s1_char_in  = s1_char_ff;
      s1_count_in = s1_count_ff;
      s1_row_in   = s1_row_ff;
      s1_col_in   = s1_col_ff;
      s1_ovf_in   = s1_ovf_ff;
      if (s1_free) begin
         s1_valid_in = req_valid;
         s1_frow_in  = step_fill_row;
         s1_fcol_in  = step_fill_col;
         s1_char_in  = step_fill_char;
         s1_count_in = step_fill_count;
         s1_row_in   = step_next_row;
         s1_col_in   = step_next_col;
         s1_ovf_in   = step_overflow;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_cursor_in = rsp_cursor_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      if (out_open) begin
         rsp_valid_in  = s1_valid_ff;
         rsp_start_in  = fill_cell;
         rsp_char_in   = s1_char_ff;
         rsp_count_in  = COUNT_W'(s1_count_ff);
         rsp_cursor_in = cursor_cell;
         rsp_ovf_in    = s1_ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff   <= COLUMNS_RESET;
         rows_ff      <= ROWS_RESET;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         columns_ff   <= columns_in;
         rows_ff      <= rows_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_frow_ff    <= s1_frow_in;
      s1_fcol_ff    <= s1_fcol_in;
      s1_char_ff    <= s1_char_in;
      s1_count_ff   <= s1_count_in;
      s1_row_ff     <= s1_row_in;
      s1_col_ff     <= s1_col_in;
      s1_ovf_ff     <= s1_ovf_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_cursor_ff <= rsp_cursor_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fill_start   = rsp_start_ff;
   assign rsp_fill_char    = rsp_char_ff;
   assign rsp_fill_count   = rsp_count_ff;
   assign rsp_cursor_pos   = rsp_cursor_ff;
   assign rsp_row_overflow = rsp_ovf_ff;

   // an empty fill run only comes from backspace at the origin
   a_empty_fill_at_origin: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_count_ff == '0 |->
         s1_row_ff == '0 && s1_col_ff == '0 && s1_char_ff == CH_NONE)
      else $error("empty fill run away from the origin");

   // overflow only follows a wrap, which leaves the cursor at column zero
   a_overflow_after_wrap: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_ovf_ff |-> s1_col_ff == '0)
      else $error("row overflow without a line wrap");

   // a word in the first stage reaches an empty output register next cycle
   a_stage_advance: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !rsp_valid_ff |=> rsp_valid_ff)
      else $error("first stage word did not advance");

endmodule

// ===== sim/text_console_cursor_writer_core_tb.sv =====
`timescale 1ns / 1ps

import tccw_pkg::*;

localparam int COLS_LIMIT = 128;
localparam int ROWS_LIMIT = 64;
localparam int TAB_PITCH  = 8;

class cursor_scoreboard;
   typedef struct {
      logic [CELL_W-1:0]  start;
      logic [CHAR_W-1:0]  ch;
      logic [COUNT_W-1:0] count;
      logic [CELL_W-1:0]  cursor;
      logic               ovf;
   } fill_run_type;

   logic [COLUMNS_W-1:0]   columns;
   logic [ROWS_W-1:0]      rows;
   logic [START_ROW_W-1:0] cur_row;
   logic [START_COL_W-1:0] cur_col;
   fill_run_type           fill_runs[$];
   int mismatches, checked, n_chars, n_bs, n_tab, n_newline, n_overflow;

   function new();
      columns    = COLUMNS_RESET;
      rows       = ROWS_RESET;
      cur_row    = '0;
      cur_col    = '0;
      mismatches = 0;
      checked    = 0;
      n_chars    = 0;
      n_bs       = 0;
      n_tab      = 0;
      n_newline  = 0;
      n_overflow = 0;
   endfunction

   function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_COLUMNS:   columns = data;
         REG_ROWS:      rows    = data[ROWS_W-1:0];
         REG_START_ROW: cur_row = data[START_ROW_W-1:0];
         REG_START_COL: cur_col = data[START_COL_W-1:0];
         default: ;
      endcase
   endfunction

   // one fill run per character, cursor moves as it goes
   function void note_char(logic [CHAR_W-1:0] c);
      int nc, nr, row, col, stop, fstart, fcount;
      logic [CHAR_W-1:0] fchar;
      logic ovf;
      fill_run_type r;
      nc  = (columns == 0) ? 1 : ((columns > COLS_LIMIT) ? COLS_LIMIT : int'(columns));
      nr  = (rows == 0) ? 1 : ((rows > ROWS_LIMIT) ? ROWS_LIMIT : int'(rows));
      row = (cur_row >= nr) ? nr - 1 : int'(cur_row);
      col = (cur_col >= nc) ? nc - 1 : int'(cur_col);
      ovf = 1'b0;
      n_chars++;
      if (c == CH_BS) begin
         n_bs++;
         if (row == 0 && col == 0) begin
            fstart = 0;
            fchar  = CH_NONE;
            fcount = 0;
         end else begin
            if (col != 0) begin
               col--;
            end else begin
               row--;
               col = nc - 1;
            end
            fstart = row * nc + col;
            fchar  = CH_SPACE;
            fcount = 1;
         end
      end else begin
         fstart = row * nc + col;
         if (c == CH_CR || c == CH_LF) begin
            n_newline++;
            fchar = CH_SPACE;
            stop  = nc;
         end else if (c == CH_TAB) begin
            n_tab++;
            fchar = CH_SPACE;
            stop  = (col / TAB_PITCH + 1) * TAB_PITCH;
            if (stop > nc) stop = nc;
         end else begin
            fchar = c;
            stop  = col + 1;
         end
         fcount = stop - col;
         col    = stop;
         if (col >= nc) begin
            col = 0;
            row++;
         end
         if (row >= nr) begin
            row = nr - 1;
            ovf = 1'b1;
            n_overflow++;
         end
      end
      cur_row  = START_ROW_W'(row);
      cur_col  = START_COL_W'(col);
      r.start  = CELL_W'(fstart);
      r.ch     = fchar;
      r.count  = COUNT_W'(fcount);
      r.cursor = CELL_W'(row * nc + col);
      r.ovf    = ovf;
      fill_runs.push_back(r);
   endfunction

   function void check_fill_run(logic [CELL_W-1:0] start, logic [CHAR_W-1:0] ch,
                                logic [COUNT_W-1:0] count, logic [CELL_W-1:0] cursor,
                                logic ovf);
      fill_run_type want;
      if (fill_runs.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected fill run: start=%0d char=%02h count=%0d cursor=%0d ovf=%0b",
                     start, ch, count, cursor, ovf);
         return;
      end
      want = fill_runs.pop_front();
      checked++;
      if (want.start !== start || want.ch !== ch || want.count !== count ||
          want.cursor !== cursor || want.ovf !== ovf) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("fill run %0d mismatch at %0t", checked, $realtime);
            $display("   want start=%0d char=%02h count=%0d cursor=%0d ovf=%0b",
                     want.start, want.ch, want.count, want.cursor, want.ovf);
            $display("   got  start=%0d char=%02h count=%0d cursor=%0d ovf=%0b",
                     start, ch, count, cursor, ovf);
         end
      end
   endfunction
endclass

module text_console_cursor_writer_core_tb;

   localparam int CYCLE_LIMIT      = 400000;
   localparam int PHASES           = 14;
   localparam int ITEMS_PER_PHASE  = 100;
   localparam int HOLD_CYCLES      = 80;
   localparam int REG_UNUSED_FIRST = int'(REG_START_COL) + 1;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [CHAR_W-1:0]      req_ch = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [CELL_W-1:0]      rsp_fill_start;
   logic [CHAR_W-1:0]      rsp_fill_char;
   logic [COUNT_W-1:0]     rsp_fill_count;
   logic [CELL_W-1:0]      rsp_cursor_pos;
   logic                   rsp_row_overflow;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   bit tx_calm = 1'b0;
   bit rx_calm = 1'b0;
   bit pressure_go = 1'b0;
   bit hold_off = 1'b0;
   bit stall_next = 1'b0;
   int stall_left = 0;
   int cycles = 0;
   int n_settings = 0;

   cursor_scoreboard sb = new();

   text_console_cursor_writer_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_ch           (req_ch),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_fill_start   (rsp_fill_start),
      .rsp_fill_char    (rsp_fill_char),
      .rsp_fill_count   (rsp_fill_count),
      .rsp_cursor_pos   (rsp_cursor_pos),
      .rsp_row_overflow (rsp_row_overflow),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("text_console_cursor_writer_core verification failed");
         $finish;
      end
   end

   // result side: check on accept, then draw the stall before the next word
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_fill_run(rsp_fill_start, rsp_fill_char, rsp_fill_count,
                           rsp_cursor_pos, rsp_row_overflow);
         stall_left = rx_calm ? 0 : $urandom_range(0, 13);
      end
      if (stall_left > 0) begin
         stall_next = 1'b1;
         stall_left--;
      end else begin
         stall_next = 1'b0;
      end
   end

   always @(negedge clock) rsp_stall <= stall_next || hold_off;

   // long receiver hold-off so the pipe backs up into req_stall
   initial begin
      wait (pressure_go);
      @(posedge clock);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off = 1'b0;
   end

   task automatic send_char(input logic [CHAR_W-1:0] c);
      int gap;
      gap = tx_calm ? 0 : $urandom_range(0, 13);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_ch    <= c;
      do @(posedge clock); while (req_stall);
      sb.note_char(c);
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (sb.fill_runs.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_grid(input logic [CSR_DATA_W-1:0] cols, input logic [CSR_DATA_W-1:0] nrows,
                           input logic [CSR_DATA_W-1:0] srow, input logic [CSR_DATA_W-1:0] scol);
      wait_drained();
      write_csr(REG_COLUMNS, cols);
      write_csr(REG_ROWS, nrows);
      write_csr(REG_START_ROW, srow);
      write_csr(REG_START_COL, scol);
      n_settings++;
   endtask

   task automatic random_config();
      logic [CSR_DATA_W-1:0] cols, nrows;
      case ($urandom_range(0, 7))
         0: cols = 8'd1;
         1: cols = 8'd128;
         2: cols = 8'd0;
         3: cols = 8'd255;
         4: cols = 8'd80;
         5: cols = CSR_DATA_W'($urandom_range(2, 16));
         default: cols = CSR_DATA_W'($urandom_range(1, 255));
      endcase
      case ($urandom_range(0, 6))
         0: nrows = 8'd1;
         1: nrows = 8'd64;
         2: nrows = 8'd0;
         3: nrows = 8'd127;
         4: nrows = CSR_DATA_W'($urandom_range(2, 8));
         default: nrows = CSR_DATA_W'($urandom_range(0, 255));
      endcase
      write_csr(REG_COLUMNS, cols);
      write_csr(REG_ROWS, nrows);
      // sometimes keep the cursor where the last phase left it
      if ($urandom_range(0, 3) != 0)
         write_csr(REG_START_ROW, CSR_DATA_W'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) != 0)
         write_csr(REG_START_COL, CSR_DATA_W'($urandom_range(0, 255)));
      if ($urandom_range(0, 2) == 0)
         write_csr(CSR_INDEX_W'(REG_UNUSED_FIRST + $urandom_range(0, 11)),
                   CSR_DATA_W'($urandom_range(0, 255)));
      n_settings++;
   endtask

   function automatic logic [CHAR_W-1:0] pick_char();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 45) return CHAR_W'($urandom_range(32, 126));
      else if (sel < 60) return CH_TAB;
      else if (sel < 70) return ($urandom_range(0, 1) != 0) ? CH_LF : CH_CR;
      else if (sel < 85) return CH_BS;
      else return CHAR_W'($urandom_range(0, 255));
   endfunction

   initial begin
      int p, k, n;
      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // reset grid 80x25, cursor at the origin
      send_char(CH_BS);
      send_char(8'h41);
      send_char(8'h00);
      send_char(8'hff);
      send_char(CH_TAB);
      send_char(CH_TAB);
      send_char(CH_CR);
      send_char(CH_BS);
      send_char(CH_LF);
      send_char(8'h7f);
      send_char(8'h80);
      end_burst();

      // zero sizes saturate to a single cell
      set_grid(8'd0, 8'd0, 8'd0, 8'd0);
      write_csr(CSR_INDEX_W'(REG_UNUSED_FIRST), 8'hff);
      send_char(8'h5a);
      send_char(CH_BS);
      send_char(CH_TAB);
      end_burst();

      // oversized grid, cursor in the bottom-right corner
      set_grid(8'd255, 8'd127, 8'd63, 8'd127);
      send_char(CH_TAB);
      send_char(CH_CR);
      send_char(CH_BS);
      send_char(8'haa);
      end_burst();

      // cursor written outside a small grid
      set_grid(8'd40, 8'd10, 8'd255, 8'd255);
      send_char(8'h55);
      send_char(CH_BS);
      send_char(CH_TAB);
      send_char(CH_LF);
      end_burst();

      for (p = 0; p < PHASES; p++) begin
         wait_drained();
         random_config();
         tx_calm = (p % 4 == 1) || (p == 3);
         rx_calm = (p % 4 == 2);
         if (p == 3) pressure_go = 1'b1;
         n = 0;
         while (n < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 24) == 0) begin
               // backspace run, often far enough to reach the origin
               k = $urandom_range(3, 40);
               repeat (k) send_char(CH_BS);
               n += k;
            end else begin
               send_char(pick_char());
               n++;
            end
         end
         end_burst();
      end
      tx_calm = 1'b0;
      rx_calm = 1'b0;

      wait_drained();
      repeat (10) @(posedge clock);
      $display("run covered %0d characters (%0d backspace, %0d tab, %0d newline), %0d overflows",
               sb.n_chars, sb.n_bs, sb.n_tab, sb.n_newline, sb.n_overflow);
      $display("%0d grid settings, %0d fill runs checked, %0d mismatches",
               n_settings, sb.checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.fill_runs.size() == 0) begin
         $display("text_console_cursor_writer_core verification clean");
      end else begin
         $display("text_console_cursor_writer_core verification failed");
      end
      $finish;
   end

endmodule

// ===== text_console_cursor_writer_core.f =====
rtl/tccw_pkg.sv
rtl/tccw_step.sv
rtl/tccw_index.sv
rtl/text_console_cursor_writer_core.sv
sim/text_console_cursor_writer_core_tb.sv
